>>> design/gpe_pkg.sv
// ----------------------------------------------------------------------------
// gpe_pkg
// Types, constants and saturating helpers for the gravity pull / Euler step
// engine.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int WORD_BITS     = 48;
  localparam int FRAC_BITS     = 32;
  localparam int MAG_BITS      = 64;
  localparam int WIDE_BITS     = MAG_BITS + 2;
  localparam int SQ_BITS       = 2 * WORD_BITS;
  localparam int ACC_BITS      = SQ_BITS + 1;
  localparam int ROOT_BITS     = WORD_BITS;
  localparam int QUO_BITS      = 64;
  localparam int F_BITS        = QUO_BITS - 1;
  localparam int UX_BITS       = FRAC_BITS + 1;
  localparam int CNT_BITS      = 7;
  localparam int OM_BITS       = 16;
  localparam int TS_BITS       = 32;
  localparam int GS_BITS       = 32;
  localparam int BM_BITS       = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CNT_BITS-1:0] SQ_STEPS  = CNT_BITS'(WORD_BITS - 1);
  localparam logic [CNT_BITS-1:0] RT_STEPS  = CNT_BITS'(ROOT_BITS - 1);
  localparam logic [CNT_BITS-1:0] KM_STEPS  = CNT_BITS'(BM_BITS - 1);
  localparam logic [CNT_BITS-1:0] DF_STEPS  = CNT_BITS'(QUO_BITS - 1);
  localparam logic [CNT_BITS-1:0] DU_STEPS  = CNT_BITS'(UX_BITS - 1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_MASS      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRUST_STEP   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRAVITY_SCALE = 2'd2;

  localparam logic [OM_BITS-1:0] OWN_MASS_RST      = 16'd20;
  localparam logic [TS_BITS-1:0] THRUST_STEP_RST   = 32'd429497;
  localparam logic [GS_BITS-1:0] GRAVITY_SCALE_RST = 32'd4294967;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam wide_t WIDE_MAX = WIDE_BITS'(WORD_MAX);
  localparam wide_t WIDE_MIN = WIDE_BITS'(WORD_MIN);
  localparam logic [F_BITS-1:0] F_MAX = {F_BITS{1'b1}};

  typedef enum logic [1:0] {
    ACT_PULL    = 2'd0,
    ACT_THRUST  = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_CHK,
    ST_K1,
    ST_K2,
    ST_DIVF,
    ST_DIVX,
    ST_MULX,
    ST_DIVY,
    ST_MULY,
    ST_EMIT
  } gpe_state_t;

  typedef struct packed {
    logic [1:0]         action;
    word_t              body_x;
    word_t              body_y;
    logic [BM_BITS-1:0] body_mass;
    logic               key_left;
    logic               key_right;
    logic               key_up;
    logic               key_down;
  } item_t;

  typedef struct packed {
    word_t pos_x_out;
    word_t pos_y_out;
    word_t vel_x_out;
    word_t vel_y_out;
    logic  pulled;
    logic  saturated;
  } result_t;

  typedef struct packed {
    logic [OM_BITS-1:0] own_mass;
    logic [TS_BITS-1:0] thrust_step;
    logic [GS_BITS-1:0] gravity_scale;
  } cfg_t;

  typedef struct packed {
    logic [ACC_BITS-1:0] a;
    logic [ACC_BITS-1:0] b;
    logic                sub;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_BITS-1:0] sum;
    logic                ge;
  } alu_rsp_t;

  typedef struct packed {
    word_t val;
    logic  hit;
  } sat_t;

  function automatic sat_t sat_move(word_t a, logic down, logic [MAG_BITS-1:0] mag);
    wide_t wa;
    wide_t wm;
    wide_t wr;
    sat_t  r;
    wa = WIDE_BITS'(a);
    wm = wide_t'({2'b00, mag});
    wr = down ? wa - wm : wa + wm;
    r.val = word_t'(wr[WORD_BITS-1:0]);
    r.hit = 1'b0;
    if (wr > WIDE_MAX) begin
      r.val = WORD_MAX;
      r.hit = 1'b1;
    end else if (wr < WIDE_MIN) begin
      r.val = WORD_MIN;
      r.hit = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] mag_of(word_t a);
    return a[WORD_BITS-1] ? (~a + 1'b1) : a;
  endfunction

endpackage

>>> design/gpe_ifs.sv
// ----------------------------------------------------------------------------
// gpe_ifs
// Request and result channel interfaces, valid/ready with payload.
// ----------------------------------------------------------------------------
interface gpe_in_if import gpe_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  word_t              body_x;
  word_t              body_y;
  logic [BM_BITS-1:0] body_mass;
  logic               key_left;
  logic               key_right;
  logic               key_up;
  logic               key_down;

  modport source (output valid, action, body_x, body_y, body_mass,
                  key_left, key_right, key_up, key_down, input ready);
  modport sink   (input valid, action, body_x, body_y, body_mass,
                  key_left, key_right, key_up, key_down, output ready);
endinterface

interface gpe_out_if import gpe_pkg::*;;
  logic  valid;
  logic  ready;
  word_t pos_x_out;
  word_t pos_y_out;
  word_t vel_x_out;
  word_t vel_y_out;
  logic  pulled;
  logic  saturated;

  modport source (output valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                  pulled, saturated, input ready);
  modport sink   (input valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                  pulled, saturated, output ready);
endinterface

>>> design/gravity_pull_euler_step_top.sv
// ----------------------------------------------------------------------------
// gravity_pull_euler_step_top
// One body's position and velocity under gravity pulls, key thrust and
// Euler advance, signed Q16.32 with saturation.
// ----------------------------------------------------------------------------
// Thrust, advance and unused actions pass from the engine's emit state to the result register.
// A pull inside the skip distance ends after the square root check; a full pull
// runs bit-serial square, root, divide and multiply on one shared adder.
// One request in flight; a new request is taken while a result waits.
// Synchronous active-low reset clears state, config to defaults, no result.
// ----------------------------------------------------------------------------
module gravity_pull_euler_step_top import gpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  gpe_in_if.sink                   in_ch,
  gpe_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg_r;
  result_t out_res_r;
  logic    out_valid_r;
  item_t   item;
  result_t res;
  logic    res_valid, res_take, eng_ready;

  assign item = '{action: in_ch.action, body_x: in_ch.body_x,
                  body_y: in_ch.body_y, body_mass: in_ch.body_mass,
                  key_left: in_ch.key_left, key_right: in_ch.key_right,
                  key_up: in_ch.key_up, key_down: in_ch.key_down};
  assign in_ch.ready = eng_ready;
  assign res_take    = res_valid && (!out_valid_r || out_ch.ready);

  gpe_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_item   (item),
    .in_ready  (eng_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_mass      <= OWN_MASS_RST;
      cfg_r.thrust_step   <= THRUST_STEP_RST;
      cfg_r.gravity_scale <= GRAVITY_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_OWN_MASS:      cfg_r.own_mass      <= cfg_data[OM_BITS-1:0];
        CFG_THRUST_STEP:   cfg_r.thrust_step   <= cfg_data[TS_BITS-1:0];
        CFG_GRAVITY_SCALE: cfg_r.gravity_scale <= cfg_data[GS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_take || (out_valid_r && !out_ch.ready);
    end
    if (res_take) out_res_r <= res;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pos_x_out = out_res_r.pos_x_out;
  assign out_ch.pos_y_out = out_res_r.pos_y_out;
  assign out_ch.vel_x_out = out_res_r.vel_x_out;
  assign out_ch.vel_y_out = out_res_r.vel_y_out;
  assign out_ch.pulled    = out_res_r.pulled;
  assign out_ch.saturated = out_res_r.saturated;

endmodule

>>> design/gpe_alu.sv
// ----------------------------------------------------------------------------
// gpe_alu
// Shared wide adder/subtractor; ge is the no-borrow flag on subtract.
// ----------------------------------------------------------------------------
module gpe_alu import gpe_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ACC_BITS:0] full;

  assign full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
              + (ACC_BITS+1)'(req.sub);
  assign rsp.sum = full[ACC_BITS-1:0];
  assign rsp.ge  = full[ACC_BITS];

endmodule

>>> design/gpe_engine.sv
// ----------------------------------------------------------------------------
// gpe_engine
// Body state and sequencer: shift-add multiply, restoring divide and
// digit-by-digit square root, all on one shared adder.
// ----------------------------------------------------------------------------
module gpe_engine import gpe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  item_t   in_item,
  output logic    in_ready,
  output logic    res_valid,
  output result_t res,
  input  logic    res_take
);

  gpe_state_t state_r, state_nxt;

  word_t pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  word_t dx_r, dy_r;
  logic [BM_BITS-1:0]   bm_r;
  logic                 sat_r, pulled_r;
  logic [ACC_BITS-1:0]  acc_r, opa_r;
  logic [QUO_BITS-1:0]  opb_r;
  logic [SQ_BITS-1:0]   src_r, s_r;
  logic [ROOT_BITS-1:0] droot_r;
  logic [F_BITS-1:0]    f_r;
  logic [CNT_BITS-1:0]  cnt_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic                 accept, last, too_near;
  logic [ACC_BITS-1:0]  sqrt_rem, sqrt_trial, div_rem, div_den;
  logic [ACC_BITS-1:0]  mul_acc, div_acc, sqrt_acc;
  logic [QUO_BITS-1:0]  q_nxt;
  logic [WORD_BITS-1:0] mx, my, in_mx, in_my;
  logic [MAG_BITS-1:0]  half, step;
  sat_t cx, cy, pdx, pdy, kl, kr, ku, kd, ax, ay, vx, vy;

  gpe_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  assign accept = in_valid && in_ready;
  assign last   = (cnt_r == '0);

  // pull front end and thrust/advance updates
  always_comb begin
    half  = MAG_BITS'(cfg.own_mass) << (FRAC_BITS - 1);
    step  = MAG_BITS'(cfg.thrust_step) << (FRAC_BITS - TS_BITS);
    cx    = sat_move(pos_x_r, 1'b0, half);
    cy    = sat_move(pos_y_r, 1'b0, half);
    pdx   = sat_move(cx.val, ~in_item.body_x[WORD_BITS-1],
                     MAG_BITS'(mag_of(in_item.body_x)));
    pdy   = sat_move(cy.val, ~in_item.body_y[WORD_BITS-1],
                     MAG_BITS'(mag_of(in_item.body_y)));
    in_mx = mag_of(pdx.val);
    in_my = mag_of(pdy.val);
    kl = in_item.key_left  ? sat_move(vel_x_r, 1'b1, step) : '{vel_x_r, 1'b0};
    kr = in_item.key_right ? sat_move(kl.val, 1'b0, step)  : '{kl.val, 1'b0};
    ku = in_item.key_up    ? sat_move(vel_y_r, 1'b1, step) : '{vel_y_r, 1'b0};
    kd = in_item.key_down  ? sat_move(ku.val, 1'b0, step)  : '{ku.val, 1'b0};
    ax = sat_move(pos_x_r, vel_x_r[WORD_BITS-1], MAG_BITS'(mag_of(vel_x_r)));
    ay = sat_move(pos_y_r, vel_y_r[WORD_BITS-1], MAG_BITS'(mag_of(vel_y_r)));
  end

  // shared unit operand selection
  always_comb begin
    mx         = mag_of(dx_r);
    my         = mag_of(dy_r);
    sqrt_rem   = {acc_r[ACC_BITS-3:0], src_r[SQ_BITS-1 -: 2]};
    sqrt_trial = ACC_BITS'({opb_r[ROOT_BITS-1:0], 2'b01});
    div_rem    = {acc_r[ACC_BITS-2:0], src_r[SQ_BITS-1]};
    div_den    = (state_r == ST_DIVF) ? ACC_BITS'(s_r) : ACC_BITS'(droot_r);
    case (state_r)
      ST_SQRT: alu_req = '{a: sqrt_rem, b: sqrt_trial, sub: 1'b1};
      ST_DIVF, ST_DIVX, ST_DIVY: alu_req = '{a: div_rem, b: div_den, sub: 1'b1};
      default: alu_req = '{a: acc_r, b: opa_r, sub: 1'b0};
    endcase
    mul_acc  = opb_r[0] ? alu_rsp.sum : acc_r;
    div_acc  = alu_rsp.ge ? alu_rsp.sum : div_rem;
    sqrt_acc = alu_rsp.ge ? alu_rsp.sum : sqrt_rem;
    q_nxt    = {opb_r[QUO_BITS-2:0], alu_rsp.ge};
    vx       = sat_move(vel_x_r, ~dx_r[WORD_BITS-1],
                        mul_acc[FRAC_BITS +: MAG_BITS]);
    vy       = sat_move(vel_y_r, ~dy_r[WORD_BITS-1],
                        mul_acc[FRAC_BITS +: MAG_BITS]);
    too_near = MAG_BITS'(opb_r[ROOT_BITS-1:0])
               <= (MAG_BITS'(cfg.own_mass) << FRAC_BITS);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (action_t'(in_item.action) == ACT_PULL) ? ST_SQX : ST_EMIT;
        end
      end
      ST_SQX:  if (last) state_nxt = ST_SQY;
      ST_SQY:  if (last) state_nxt = ST_SQRT;
      ST_SQRT: if (last) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = too_near ? ST_EMIT : ST_K1;
      ST_K1:   if (last) state_nxt = ST_K2;
      ST_K2:   if (last) state_nxt = ST_DIVF;
      ST_DIVF: if (last) state_nxt = ST_DIVX;
      ST_DIVX: if (last) state_nxt = ST_MULX;
      ST_MULX: if (last) state_nxt = ST_DIVY;
      ST_DIVY: if (last) state_nxt = ST_MULY;
      ST_MULY: if (last) state_nxt = ST_EMIT;
      ST_EMIT: if (res_take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    res_valid     = (state_r == ST_EMIT);
    res.pos_x_out = pos_x_r;
    res.pos_y_out = pos_y_r;
    res.vel_x_out = vel_x_r;
    res.vel_y_out = vel_y_r;
    res.pulled    = pulled_r;
    res.saturated = sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (!last) cnt_r <= cnt_r - 1'b1;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            sat_r    <= 1'b0;
            pulled_r <= 1'b0;
            bm_r     <= in_item.body_mass;
            case (action_t'(in_item.action))
              ACT_PULL: begin
                dx_r  <= pdx.val;
                dy_r  <= pdy.val;
                sat_r <= cx.hit | cy.hit | pdx.hit | pdy.hit;
                acc_r <= '0;
                opa_r <= ACC_BITS'(in_mx);
                opb_r <= QUO_BITS'(in_mx);
                cnt_r <= SQ_STEPS;
              end
              ACT_THRUST: begin
                vel_x_r <= kr.val;
                vel_y_r <= kd.val;
                sat_r   <= kl.hit | kr.hit | ku.hit | kd.hit;
              end
              ACT_ADVANCE: begin
                pos_x_r <= ax.val;
                pos_y_r <= ay.val;
                sat_r   <= ax.hit | ay.hit;
              end
              default: ;
            endcase
          end
        end
        ST_SQX, ST_SQY, ST_K1, ST_K2, ST_MULX, ST_MULY: begin
          acc_r <= mul_acc;
          opa_r <= {opa_r[ACC_BITS-2:0], 1'b0};
          opb_r <= {1'b0, opb_r[QUO_BITS-1:1]};
          if (last) begin
            case (state_r)
              ST_SQX: begin
                opa_r <= ACC_BITS'(my);
                opb_r <= QUO_BITS'(my);
                cnt_r <= SQ_STEPS;
              end
              ST_SQY: begin
                s_r   <= mul_acc[SQ_BITS-1:0];
                src_r <= mul_acc[SQ_BITS-1:0];
                acc_r <= '0;
                opb_r <= '0;
                cnt_r <= RT_STEPS;
              end
              ST_K1: begin
                acc_r <= '0;
                opa_r <= mul_acc;
                opb_r <= QUO_BITS'(bm_r);
                cnt_r <= KM_STEPS;
              end
              ST_K2: begin
                opb_r <= '0;
                cnt_r <= DF_STEPS;
              end
              ST_MULX: begin
                vel_x_r <= vx.val;
                sat_r   <= sat_r | vx.hit;
                acc_r   <= ACC_BITS'(my >> 1);
                src_r   <= {my[0], {(SQ_BITS-1){1'b0}}};
                opb_r   <= '0;
                cnt_r   <= DU_STEPS;
              end
              default: begin
                vel_y_r <= vy.val;
                sat_r   <= sat_r | vy.hit;
              end
            endcase
          end
        end
        ST_SQRT: begin
          acc_r <= sqrt_acc;
          opb_r <= q_nxt;
          src_r <= {src_r[SQ_BITS-3:0], 2'b00};
        end
        ST_CHK: begin
          droot_r <= opb_r[ROOT_BITS-1:0];
          if (!too_near) begin
            pulled_r <= 1'b1;
            acc_r    <= '0;
            opa_r    <= ACC_BITS'(cfg.gravity_scale);
            opb_r    <= QUO_BITS'(cfg.own_mass);
            cnt_r    <= KM_STEPS;
          end
        end
        ST_DIVF, ST_DIVX, ST_DIVY: begin
          acc_r <= div_acc;
          opb_r <= q_nxt;
          src_r <= {src_r[SQ_BITS-2:0], 1'b0};
          if (last) begin
            opb_r <= q_nxt;
            acc_r <= '0;
            cnt_r <= DU_STEPS;
            if (state_r == ST_DIVF) begin
              // quotient at or above 2^63 clamps the force
              f_r   <= q_nxt[QUO_BITS-1] ? F_MAX : q_nxt[F_BITS-1:0];
              sat_r <= sat_r | q_nxt[QUO_BITS-1];
              acc_r <= ACC_BITS'(mx >> 1);
              src_r <= {mx[0], {(SQ_BITS-1){1'b0}}};
              opb_r <= '0;
            end else begin
              opa_r <= ACC_BITS'(f_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> verif/tb_gravity_pull_euler_step_top.sv
// ----------------------------------------------------------------------------
// tb_gravity_pull_euler_step_top
// Self-checking bench for the gravity pull / Euler step engine. A driver feeds
// requests from a pending queue and a monitor predicts each accepted request,
// then checks every result field in order. Directed requests come first, then
// random phases under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_gravity_pull_euler_step_top import gpe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_CYCLES = 4000000;
  localparam logic [63:0] FORCE_TOP  = 64'h7FFF_FFFF_FFFF_FFFF;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  gpe_in_if  in_bus ();
  gpe_out_if out_bus ();

  gravity_pull_euler_step_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // model state and register copies
  word_t              px, py, vx, vy;
  logic [OM_BITS-1:0] om;
  logic [TS_BITS-1:0] ts;
  logic [GS_BITS-1:0] gs;
  logic               sat_seen;

  item_t   pend_q[$];
  result_t body_q[$];
  int      errors;
  int      cycles;
  int      send_idle;
  int      recv_idle;
  logic    in_took;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic word_t bump(word_t a, logic down, logic [63:0] mag);
    logic signed [67:0] w;
    logic signed [67:0] m;
    w = a;
    m = $signed({4'b0, mag});
    w = down ? w - m : w + m;
    if (w > WORD_MAX) begin
      sat_seen = 1'b1;
      return WORD_MAX;
    end
    if (w < WORD_MIN) begin
      sat_seen = 1'b1;
      return WORD_MIN;
    end
    return word_t'(w[WORD_BITS-1:0]);
  endfunction

  function automatic logic [63:0] mag64(word_t a);
    logic signed [64:0] w;
    w = a;
    return w < 0 ? 64'(-w) : 64'(w);
  endfunction

  function automatic logic [63:0] clip_quot(logic [127:0] q);
    if (q >= (128'd1 << 63)) begin
      sat_seen = 1'b1;
      return FORCE_TOP;
    end
    return q[63:0];
  endfunction

  task automatic step_body(input item_t it, output result_t r);
    logic [63:0]  half, mx, my, root, cand, f, ux, uy, k;
    logic [127:0] s, prod_x, prod_y;
    word_t        dx, dy;
    logic         pulled;
    pulled   = 1'b0;
    sat_seen = 1'b0;
    case (action_t'(it.action))
      ACT_PULL: begin
        half = 64'(om) << (FRAC_BITS - 1);
        dx = bump(bump(px, 1'b0, half), it.body_x >= 0, mag64(it.body_x));
        dy = bump(bump(py, 1'b0, half), it.body_y >= 0, mag64(it.body_y));
        mx = mag64(dx);
        my = mag64(dy);
        s = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
          cand = root | (64'd1 << b);
          if (128'(cand) * 128'(cand) <= s) root = cand;
        end
        if (root > (64'(om) << FRAC_BITS)) begin
          pulled = 1'b1;
          k = 64'(gs) * 64'(om) * 64'(it.body_mass);
          f = clip_quot({k, 64'd0} / s);
          ux = clip_quot((128'(mx) << FRAC_BITS) / 128'(root));
          uy = clip_quot((128'(my) << FRAC_BITS) / 128'(root));
          prod_x = 128'(f) * 128'(ux);
          prod_y = 128'(f) * 128'(uy);
          vx = bump(vx, dx >= 0, prod_x[FRAC_BITS+63:FRAC_BITS]);
          vy = bump(vy, dy >= 0, prod_y[FRAC_BITS+63:FRAC_BITS]);
        end
      end
      ACT_THRUST: begin
        if (it.key_left)  vx = bump(vx, 1'b1, 64'(ts));
        if (it.key_right) vx = bump(vx, 1'b0, 64'(ts));
        if (it.key_up)    vy = bump(vy, 1'b1, 64'(ts));
        if (it.key_down)  vy = bump(vy, 1'b0, 64'(ts));
      end
      ACT_ADVANCE: begin
        px = bump(px, vx < 0, mag64(vx));
        py = bump(py, vy < 0, mag64(vy));
      end
      default: ;
    endcase
    r.pos_x_out = px;
    r.pos_y_out = py;
    r.vel_x_out = vx;
    r.vel_y_out = vy;
    r.pulled    = pulled;
    r.saturated = sat_seen;
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h at cycle %0d", field, got, want, cycles);
  endtask

  // driver
  always @(negedge clk) begin
    item_t it;
    if (rst_n && (!in_bus.valid || in_took)) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        it = pend_q.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.action    <= it.action;
        in_bus.body_x    <= it.body_x;
        in_bus.body_y    <= it.body_y;
        in_bus.body_mass <= it.body_mass;
        in_bus.key_left  <= it.key_left;
        in_bus.key_right <= it.key_right;
        in_bus.key_up    <= it.key_up;
        in_bus.key_down  <= it.key_down;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    item_t   it;
    result_t want;
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("gravity_pull_euler_step_top verification failed");
      $finish;
    end
    in_took = rst_n && in_bus.valid && in_bus.ready;
    if (in_took) begin
      it.action    = in_bus.action;
      it.body_x    = in_bus.body_x;
      it.body_y    = in_bus.body_y;
      it.body_mass = in_bus.body_mass;
      it.key_left  = in_bus.key_left;
      it.key_right = in_bus.key_right;
      it.key_up    = in_bus.key_up;
      it.key_down  = in_bus.key_down;
      step_body(it, want);
      body_q.push_back(want);
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (body_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_bus.pos_x_out), '0);
      end else begin
        want = body_q.pop_front();
        if (out_bus.pos_x_out !== want.pos_x_out)
          report_mismatch("pos_x", 64'(out_bus.pos_x_out), 64'(want.pos_x_out));
        if (out_bus.pos_y_out !== want.pos_y_out)
          report_mismatch("pos_y", 64'(out_bus.pos_y_out), 64'(want.pos_y_out));
        if (out_bus.vel_x_out !== want.vel_x_out)
          report_mismatch("vel_x", 64'(out_bus.vel_x_out), 64'(want.vel_x_out));
        if (out_bus.vel_y_out !== want.vel_y_out)
          report_mismatch("vel_y", 64'(out_bus.vel_y_out), 64'(want.vel_y_out));
        if (out_bus.pulled !== want.pulled)
          report_mismatch("pulled", 64'(out_bus.pulled), 64'(want.pulled));
        if (out_bus.saturated !== want.saturated)
          report_mismatch("saturated", 64'(out_bus.saturated), 64'(want.saturated));
      end
    end
  end

  function automatic item_t mk(action_t a, word_t bx, word_t by, logic [BM_BITS-1:0] bm,
                               logic [3:0] keys);
    item_t it;
    it.action    = a;
    it.body_x    = bx;
    it.body_y    = by;
    it.body_mass = bm;
    {it.key_left, it.key_right, it.key_up, it.key_down} = keys;
    return it;
  endfunction

  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  // a point near the own center, sometimes exactly on it
  function automatic word_t near(word_t pos);
    word_t       c;
    logic [63:0] off;
    logic        keep;
    int          bits;
    keep = sat_seen;
    c = bump(pos, 1'b0, 64'(om) << (FRAC_BITS - 1));
    bits = $urandom_range(46, 0);
    off = {$urandom, $urandom} & ((64'd1 << bits) - 1);
    if ($urandom_range(9) == 0) off = '0;
    else if ($urandom_range(3) == 0) off = (64'(om) << FRAC_BITS) + off[31:0];
    c = bump(c, 1'($urandom_range(1)), off);
    sat_seen = keep;
    return c;
  endfunction

  function automatic item_t rand_req();
    int    pick;
    item_t it;
    pick = $urandom_range(99);
    it = mk(ACT_PULL, rand_word(), rand_word(), 16'($urandom), 4'($urandom));
    if (pick < 45) begin
      if ($urandom_range(3) != 0) begin
        it.body_x = near(px);
        it.body_y = near(py);
      end
    end else if (pick < 75) begin
      it.action = ACT_THRUST;
    end else if (pick < 95) begin
      it.action = ACT_ADVANCE;
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  // checked at the rising edge, where the driver's last update has settled
  task automatic wait_drained();
    while (pend_q.size() > 0 || body_q.size() > 0 || in_bus.valid) @(posedge clk);
  endtask

  task automatic push_single(item_t it);
    wait_drained();
    pend_q.push_back(it);
  endtask

  task automatic set_regs(logic [15:0] m, logic [31:0] t, logic [31:0] g);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= CFG_OWN_MASS;      cfg_data <= 32'(m);
    @(negedge clk);
    cfg_idx <= CFG_THRUST_STEP;   cfg_data <= t;
    @(negedge clk);
    cfg_idx <= CFG_GRAVITY_SCALE; cfg_data <= g;
    @(negedge clk);
    cfg_we <= 1'b0;
    om = m;
    ts = t;
    gs = g;
  endtask

  task automatic run_phase(int count, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int n = 0; n < count; n++) begin
      while (pend_q.size() >= 2) @(negedge clk);
      pend_q.push_back(rand_req());
    end
  endtask

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.action    = '0;
    in_bus.body_x    = '0;
    in_bus.body_y    = '0;
    in_bus.body_mass = '0;
    in_bus.key_left  = 1'b0;
    in_bus.key_right = 1'b0;
    in_bus.key_up    = 1'b0;
    in_bus.key_down  = 1'b0;
    out_bus.ready    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    in_took = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    px = '0; py = '0; vx = '0; vy = '0;
    om = OWN_MASS_RST;
    ts = THRUST_STEP_RST;
    gs = GRAVITY_SCALE_RST;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed, reset settings
    push_single(mk(ACT_THRUST, '0, '0, '0, 4'b1111));
    push_single(mk(ACT_THRUST, '0, '0, '0, 4'b1000));
    push_single(mk(ACT_THRUST, '0, '0, '0, 4'b0100));
    push_single(mk(ACT_THRUST, '0, '0, '0, 4'b0110));
    push_single(mk(ACT_THRUST, '0, '0, '0, 4'b0001));
    push_single(mk(ACT_THRUST, '0, '0, '0, 4'b0000));
    push_single(mk(ACT_ADVANCE, '0, '0, '0, 4'b0000));
    push_single(mk(ACT_NONE, WORD_MAX, WORD_MIN, 16'hFFFF, 4'b1111));
    push_single(mk(ACT_PULL, bump(px, 1'b0, 64'(om) << 31), bump(py, 1'b0, 64'(om) << 31),
                   16'hFFFF, 4'b0000));
    push_single(mk(ACT_PULL, bump(bump(px, 1'b0, 64'(om) << 31), 1'b0, (64'(om) << 32) + 1),
                   bump(py, 1'b0, 64'(om) << 31), 16'hFFFF, 4'b0000));
    push_single(mk(ACT_PULL, WORD_MAX, WORD_MAX, 16'hFFFF, 4'b0000));
    push_single(mk(ACT_PULL, WORD_MIN, WORD_MIN, 16'hFFFF, 4'b0000));
    push_single(mk(ACT_PULL, 48'sh10_0000_0000_00, '0, 16'h0000, 4'b0000));

    // directed, strong pull to drive saturation
    set_regs(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int n = 0; n < 3; n++)
      push_single(mk(ACT_PULL, bump(bump(px, 1'b0, 64'd1 << 31), 1'b0, 64'd1 << 33),
                     bump(py, 1'b0, 64'd1 << 31), 16'hFFFF, 4'b0000));
    for (int n = 0; n < 4; n++) push_single(mk(ACT_ADVANCE, '0, '0, '0, 4'b0000));
    push_single(mk(ACT_THRUST, '0, '0, '0, 4'b1111));
    set_regs(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_single(mk(ACT_PULL, '0, '0, 16'hFFFF, 4'b0000));
    push_single(mk(ACT_PULL, WORD_MIN, WORD_MAX, 16'hFFFF, 4'b0000));
    set_regs(16'd0, 32'd0, 32'd0);
    push_single(mk(ACT_PULL, px, py, 16'hFFFF, 4'b0000));
    push_single(mk(ACT_PULL, '0, '0, 16'hFFFF, 4'b0000));
    push_single(mk(ACT_THRUST, '0, '0, '0, 4'b1111));

    // random phases
    set_regs(OWN_MASS_RST, THRUST_STEP_RST, GRAVITY_SCALE_RST);
    run_phase(230, 0, 0);
    set_regs(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(230, 87, 0);
    set_regs(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(230, 0, 87);
    set_regs(16'd0, 32'd0, 32'd0);
    run_phase(230, 10, 10);
    for (int ph = 0; ph < 4; ph++) begin
      set_regs($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(300)),
               $urandom, $urandom);
      run_phase(230, ph == 1 ? 87 : (ph == 3 ? 10 : 0), ph == 2 ? 87 : (ph == 3 ? 10 : 0));
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0 && body_q.size() == 0) begin
      $display("gravity_pull_euler_step_top verification clean");
    end else begin
      $display("gravity_pull_euler_step_top verification failed");
    end
    $finish;
  end

endmodule
